// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the status LED controller.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SLIC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("status LED controller assertion failed");

// Clocked assertion that also holds during reset.
`define SLIC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("status LED controller assertion failed");

`endif

// ----- hdl/slic_pkg.sv -----
// ---------------------------------------------------------------------------
// slic_pkg
// Types, codes and reset values shared by the status LED controller.
// ---------------------------------------------------------------------------
package slic_pkg;

   localparam int TIME_BITS_DEFAULT = 32;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_PIN_POLARITY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_INTERVAL = 2'd2;

   localparam logic        PIN_POLARITY_RST   = 1'b1;
   localparam logic [15:0] PULSE_LENGTH_RST   = 16'd100;
   localparam logic [15:0] BLINK_INTERVAL_RST = 16'd2000;

   typedef enum logic [2:0] {
      OP_UPDATE       = 3'd0,
      OP_MANUAL_RELAY = 3'd1,
      OP_MANUAL_LINK  = 3'd2,
      OP_RELAY_TEST   = 3'd3,
      OP_LINK_TEST    = 3'd4,
      OP_BOTH_TEST    = 3'd5
   } op_type;

   typedef struct packed {
      logic        pin_polarity;
      logic [15:0] pulse_length_ms;
      logic [15:0] blink_interval_ms;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic        relay_on;
      logic        link_up;
      logic        manual_value;
      logic [31:0] test_duration_ms;
   } item_type;

   typedef struct packed {
      logic link_indicated;
      logic relay_indicated;
      logic link_test_active;
      logic relay_test_active;
      logic link_pin;
      logic relay_pin;
   } result_type;

endpackage

// ----- hdl/status_led_indicator_control_top.sv -----
// A transaction accepted on req is held in the input register, and its result is
// captured in the result register and offered on rsp.
// Throughput: one transaction per cycle while rsp is not stalled; the per-item
// work is a few subtractions and compares between the input and result registers.
// Reset: synchronous, active high; all LED state clears, registers take their
// defaults (active high, 100 ms pulse, 2000 ms interval), and both channels empty.
// ---------------------------------------------------------------------------
// status_led_indicator_control_top
// Relay and link indicator LED controller with a stream interface.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module status_led_indicator_control_top #(
   parameter int TIME_BITS = slic_pkg::TIME_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata, lowest bit first: now_ms[31:0], relay_on, link_up, manual_value,
   // test_duration_ms[31:0], five zero pad bits.
   input  logic [slic_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: op[2:0].
   input  logic [slic_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata, lowest bit first: relay_pin, link_pin, relay_test_active,
   // link_test_active, relay_indicated, link_indicated, two zero pad bits.
   output logic [slic_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration write port.
   input  logic                             csr_wr_en,
   input  logic [slic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slic_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slic_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_free;
   logic       advance;

   // The input register moves into the result register whenever the result
   // register is empty or its transaction is being taken in the same cycle.
   // State in the core updates on the same edge, so the next transaction
   // always sees the state left by the previous one.
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && rsp_free;
   assign req_tready = !item_valid_ff || rsp_free;

   // Unpack the request fields from the stream payload.
   always_comb begin
      item_in.op               = op_type'(req_tuser);
      item_in.now_ms           = req_tdata[31:0];
      item_in.relay_on         = req_tdata[32];
      item_in.link_up          = req_tdata[33];
      item_in.manual_value     = req_tdata[34];
      item_in.test_duration_ms = req_tdata[66:35];
   end

   slic_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slic_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   // Input register: control is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff};

   // A held request transaction moves on only when the result side has room.
   `SLIC_ASSERT(a_item_held, clock, reset,
      (item_valid_ff && rsp_valid_ff && !rsp_tready) |=> item_valid_ff)
   // A taken result with nothing behind it leaves the result register empty.
   `SLIC_ASSERT(a_rsp_drain, clock, reset,
      (rsp_valid_ff && rsp_tready && !item_valid_ff) |=> !rsp_valid_ff)
   // Every advance fills the result register on the following cycle.
   `SLIC_ASSERT(a_advance_fills, clock, reset, advance |=> rsp_valid_ff)

endmodule

// ----- hdl/slic_csr.sv -----
// ---------------------------------------------------------------------------
// slic_csr
// Configuration registers of the status LED controller.
// ---------------------------------------------------------------------------
module slic_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [slic_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [slic_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output slic_pkg::cfg_type              cfg
);
   import slic_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PIN_POLARITY:   cfg_in.pin_polarity      = csr_wdata[0];
            CSR_PULSE_LENGTH:   cfg_in.pulse_length_ms   = csr_wdata;
            CSR_BLINK_INTERVAL: cfg_in.blink_interval_ms = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_polarity      <= PIN_POLARITY_RST;
         cfg_ff.pulse_length_ms   <= PULSE_LENGTH_RST;
         cfg_ff.blink_interval_ms <= BLINK_INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/slic_core.sv -----
// ---------------------------------------------------------------------------
// slic_core
// LED state, next-state logic and result formation for one transaction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slic_core #(
   parameter int TIME_BITS = slic_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  slic_pkg::item_type   item,
   input  slic_pkg::cfg_type    cfg,
   output slic_pkg::result_type result
);
   import slic_pkg::*;

   logic last_relay_ff, last_link_ff, pulse_active_ff, link_led_on_ff;
   logic relay_manual_ff, link_manual_ff, relay_manual_val_ff, link_manual_val_ff;
   logic relay_testing_ff, link_testing_ff;
   logic [TIME_BITS-1:0] relay_deadline_ff, link_deadline_ff;
   logic [TIME_BITS-1:0] pulse_start_ff, last_blink_ff;

   logic last_relay_in, last_link_in, pulse_active_in, link_led_on_in;
   logic relay_manual_in, link_manual_in, relay_manual_val_in, link_manual_val_in;
   logic relay_testing_in, link_testing_in;
   logic [TIME_BITS-1:0] relay_deadline_in, link_deadline_in;
   logic [TIME_BITS-1:0] pulse_start_in, last_blink_in;

   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] deadline_t;
   logic [TIME_BITS-1:0] relay_left;
   logic [TIME_BITS-1:0] link_left;
   logic [TIME_BITS-1:0] pulse_age;
   logic [TIME_BITS-1:0] blink_age;
   logic                 relay_ind;
   logic                 link_ind;
   logic                 inv;

   assign now_t      = TIME_BITS'(item.now_ms);
   assign deadline_t = now_t + TIME_BITS'(item.test_duration_ms);
   assign relay_left = now_t - relay_deadline_ff;
   assign link_left  = now_t - link_deadline_ff;
   assign pulse_age  = now_t - pulse_start_ff;

   always_comb begin
      last_relay_in       = last_relay_ff;
      last_link_in        = last_link_ff;
      pulse_active_in     = pulse_active_ff;
      link_led_on_in      = link_led_on_ff;
      relay_manual_in     = relay_manual_ff;
      link_manual_in      = link_manual_ff;
      relay_manual_val_in = relay_manual_val_ff;
      link_manual_val_in  = link_manual_val_ff;
      relay_testing_in    = relay_testing_ff;
      link_testing_in     = link_testing_ff;
      relay_deadline_in   = relay_deadline_ff;
      link_deadline_in    = link_deadline_ff;
      pulse_start_in      = pulse_start_ff;
      last_blink_in       = last_blink_ff;
      blink_age           = '0;

      case (item.op)
         OP_UPDATE: begin
            // A deadline is reached once now minus deadline is non-negative.
            if (relay_testing_ff && !relay_left[TIME_BITS-1]) begin
               relay_testing_in = 1'b0;
            end
            if (link_testing_ff && !link_left[TIME_BITS-1]) begin
               link_testing_in = 1'b0;
            end
            last_relay_in = item.relay_on;

            if (item.link_up != last_link_ff) begin
               last_link_in = item.link_up;
               if (!link_manual_ff) begin
                  pulse_active_in = 1'b0;
                  if (item.link_up) begin
                     link_led_on_in = 1'b0;
                     last_blink_in  = now_t;
                  end else begin
                     link_led_on_in = 1'b1;
                  end
               end
            end

            blink_age = now_t - last_blink_in;
            if (!link_manual_ff && !item.link_up) begin
               link_led_on_in = 1'b1;
            end else if (!link_manual_ff && pulse_active_in) begin
               if (pulse_age >= TIME_BITS'(cfg.pulse_length_ms)) begin
                  pulse_active_in = 1'b0;
                  link_led_on_in  = 1'b0;
               end
            end else if (!link_manual_ff && item.link_up &&
                         blink_age >= TIME_BITS'(cfg.blink_interval_ms)) begin
               pulse_active_in = 1'b1;
               pulse_start_in  = now_t;
               last_blink_in   = now_t;
               link_led_on_in  = 1'b1;
            end
         end
         OP_MANUAL_RELAY: begin
            relay_manual_in     = 1'b1;
            relay_manual_val_in = item.manual_value;
         end
         OP_MANUAL_LINK: begin
            link_manual_in     = 1'b1;
            link_manual_val_in = item.manual_value;
         end
         OP_RELAY_TEST: begin
            relay_testing_in  = 1'b1;
            relay_deadline_in = deadline_t;
         end
         OP_LINK_TEST: begin
            link_testing_in  = 1'b1;
            link_deadline_in = deadline_t;
         end
         OP_BOTH_TEST: begin
            relay_testing_in  = 1'b1;
            relay_deadline_in = deadline_t;
            link_testing_in   = 1'b1;
            link_deadline_in  = deadline_t;
         end
         default: begin
            blink_age = '0;
         end
      endcase
   end

   always_comb begin
      relay_ind = relay_manual_in ? relay_manual_val_in : last_relay_in;
      link_ind  = link_testing_in ? 1'b1
                : (link_manual_in ? link_manual_val_in : link_led_on_in);
      inv       = ~cfg.pin_polarity;

      result.relay_pin         = (relay_testing_in | relay_ind) ^ inv;
      result.link_pin          = link_ind ^ inv;
      result.relay_test_active = relay_testing_in;
      result.link_test_active  = link_testing_in;
      result.relay_indicated   = relay_ind;
      result.link_indicated    = link_ind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_relay_ff       <= 1'b0;
         last_link_ff        <= 1'b0;
         pulse_active_ff     <= 1'b0;
         link_led_on_ff      <= 1'b0;
         relay_manual_ff     <= 1'b0;
         link_manual_ff      <= 1'b0;
         relay_manual_val_ff <= 1'b0;
         link_manual_val_ff  <= 1'b0;
         relay_testing_ff    <= 1'b0;
         link_testing_ff     <= 1'b0;
         relay_deadline_ff   <= '0;
         link_deadline_ff    <= '0;
         pulse_start_ff      <= '0;
         last_blink_ff       <= '0;
      end else if (step) begin
         last_relay_ff       <= last_relay_in;
         last_link_ff        <= last_link_in;
         pulse_active_ff     <= pulse_active_in;
         link_led_on_ff      <= link_led_on_in;
         relay_manual_ff     <= relay_manual_in;
         link_manual_ff      <= link_manual_in;
         relay_manual_val_ff <= relay_manual_val_in;
         link_manual_val_ff  <= link_manual_val_in;
         relay_testing_ff    <= relay_testing_in;
         link_testing_ff     <= link_testing_in;
         relay_deadline_ff   <= relay_deadline_in;
         link_deadline_ff    <= link_deadline_in;
         pulse_start_ff      <= pulse_start_in;
         last_blink_ff       <= last_blink_in;
      end
   end

   // Manual overrides latch until reset.
   `SLIC_ASSERT(a_relay_manual_sticky, clock, reset, relay_manual_ff |=> relay_manual_ff)
   `SLIC_ASSERT(a_link_manual_sticky, clock, reset, link_manual_ff |=> link_manual_ff)
   // A running blink pulse always has the link LED lit.
   `SLIC_ASSERT_ALWAYS(a_pulse_lit, clock, pulse_active_ff |-> link_led_on_ff)
   // An update with the link down and no override lights the link LED.
   `SLIC_ASSERT(a_link_down_lit, clock, reset,
      (step && item.op == OP_UPDATE && !item.link_up && !link_manual_ff) |=> link_led_on_ff)

endmodule
